// File: rtl/core/lnwq_pkg.sv
// lnwq_pkg: shared constants, types and the sequencer microprogram for the
// lcd nibble write queue. no dependencies; used by the interfaces and the top level.
`default_nettype none

package lnwq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int BYTE_W      = 8;
  localparam int PORT_W      = 7;

  // port bit positions
  localparam int RS_POS      = 4;
  localparam int EN_POS      = 6;

  // input opcodes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // microprogram
  localparam int PROG_LEN    = 8;
  localparam int STEP_W      = $clog2(PROG_LEN);

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,  // advance once the beat is placed
    JMP_WAIT = 2'd1,  // hold until a tick pops a byte
    JMP_HOME = 2'd2   // back to the accept step once the beat is placed
  } jump_t;

  typedef struct packed {
    logic  accept;   // input channel open
    logic  emit;     // place one port beat
    logic  en;       // enable strobe bit
    logic  lo_nib;   // low nibble instead of high
    logic  zero;     // all-zero closing beat
    logic  last;     // final beat of the byte
    jump_t jump;
  } ctrl_word_t;

  localparam step_t STEP_HOME  = step_t'(0);
  localparam step_t STEP_FIRST = step_t'(1);

  function automatic ctrl_word_t ctrl_rom(input step_t step);
    ctrl_word_t cw;
    cw = '{accept: 1'b0, emit: 1'b0, en: 1'b0, lo_nib: 1'b0, zero: 1'b0,
           last: 1'b0, jump: JMP_HOME};
    case (step)
      step_t'(0): begin
        cw.accept = 1'b1;
        cw.jump   = JMP_WAIT;
      end
      step_t'(1): begin
        cw.emit = 1'b1;
        cw.jump = JMP_NEXT;
      end
      step_t'(2): begin
        cw.emit = 1'b1;
        cw.en   = 1'b1;
        cw.jump = JMP_NEXT;
      end
      step_t'(3): begin
        cw.emit = 1'b1;
        cw.jump = JMP_NEXT;
      end
      step_t'(4): begin
        cw.emit   = 1'b1;
        cw.lo_nib = 1'b1;
        cw.jump   = JMP_NEXT;
      end
      step_t'(5): begin
        cw.emit   = 1'b1;
        cw.lo_nib = 1'b1;
        cw.en     = 1'b1;
        cw.jump   = JMP_NEXT;
      end
      step_t'(6): begin
        cw.emit   = 1'b1;
        cw.lo_nib = 1'b1;
        cw.jump   = JMP_NEXT;
      end
      step_t'(7): begin
        cw.emit = 1'b1;
        cw.zero = 1'b1;
        cw.last = 1'b1;
        cw.jump = JMP_HOME;
      end
      default: begin
        cw.jump = JMP_HOME;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lnwq_intf.sv
// lnwq_in_if / lnwq_out_if: valid-ready channels for queue items and port beats
// depends on lnwq_pkg for payload widths
`default_nettype none

interface lnwq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [lnwq_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface lnwq_out_if;
  logic                        valid;
  logic                        ready;
  logic [lnwq_pkg::PORT_W-1:0] port_value;
  logic                        last;

  modport source (output valid, output port_value, output last, input ready);
  modport sink   (input valid, input port_value, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lcd_nibble_write_queue.sv
// lcd_nibble_write_queue: byte queue feeding a 4-bit display port
// push: stored at the accept step; no beats. tick on a non-empty queue: accept
// step plus 7 port beats from the 8-step microprogram, one step per cycle while
// the output takes beats; the tick sets step_r and rd_data_r, then the first beat
// is registered in out_port_r. tick on empty / push to full: accepted, no beats.
// rst_n (synchronous) empties the queue and returns the sequencer to its accept step.
`default_nettype none

module lcd_nibble_write_queue (
  input  wire          clk,
  input  wire          rst_n,
  lnwq_in_if.sink      in_ch,
  lnwq_out_if.source   out_ch
);

  logic [lnwq_pkg::BYTE_W-1:0] queue_mem [lnwq_pkg::QUEUE_DEPTH];

  logic [lnwq_pkg::IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [lnwq_pkg::IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [lnwq_pkg::CNT_W-1:0]  count_r,  count_nxt;
  lnwq_pkg::step_t             step_r,   step_nxt;
  logic [lnwq_pkg::BYTE_W-1:0] rd_data_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [lnwq_pkg::PORT_W-1:0] out_port_r;
  logic                        out_last_r;

  lnwq_pkg::ctrl_word_t        cw;
  logic                        accept;
  logic                        do_push;
  logic                        do_pop;
  logic                        out_free;
  logic                        beat_go;
  logic [3:0]                  nibble;
  logic [lnwq_pkg::PORT_W-1:0] port_nxt;

  assign cw       = lnwq_pkg::ctrl_rom(step_r);
  assign accept   = in_ch.valid && cw.accept;
  assign do_push  = accept && (in_ch.opcode == lnwq_pkg::OP_PUSH) &&
                    (count_r != lnwq_pkg::CNT_W'(lnwq_pkg::QUEUE_DEPTH));
  assign do_pop   = accept && (in_ch.opcode == lnwq_pkg::OP_TICK) &&
                    (count_r != '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign beat_go  = cw.emit && out_free;

  // pointers and fill level
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_idx_nxt = (wr_idx_r == lnwq_pkg::IDX_W'(lnwq_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_idx_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (do_pop) begin
      rd_idx_nxt = (rd_idx_r == lnwq_pkg::IDX_W'(lnwq_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_idx_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  // step counter and conditional jumps
  always_comb begin
    step_nxt = step_r;
    case (cw.jump)
      lnwq_pkg::JMP_WAIT: begin
        step_nxt = do_pop ? lnwq_pkg::STEP_FIRST : lnwq_pkg::STEP_HOME;
      end
      lnwq_pkg::JMP_NEXT: begin
        if (beat_go) step_nxt = step_r + 1'b1;
      end
      lnwq_pkg::JMP_HOME: begin
        if (beat_go || !cw.emit) step_nxt = lnwq_pkg::STEP_HOME;
      end
      default: begin
        step_nxt = lnwq_pkg::STEP_HOME;
      end
    endcase
  end

  // port beat formatting; popped byte stays in rd_data_r for all seven beats
  always_comb begin
    nibble   = cw.lo_nib ? rd_data_r[3:0] : rd_data_r[7:4];
    port_nxt = '0;
    if (!cw.zero) begin
      port_nxt[3:0]                = nibble;
      port_nxt[lnwq_pkg::RS_POS]   = !rd_data_r[lnwq_pkg::BYTE_W-1];
      port_nxt[lnwq_pkg::EN_POS]   = cw.en;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (beat_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue_mem[wr_idx_r] <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      rd_data_r <= queue_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      count_r     <= '0;
      step_r      <= lnwq_pkg::STEP_HOME;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_go) begin
      out_port_r <= port_nxt;
      out_last_r <= cw.last;
    end
  end

  assign in_ch.ready       = cw.accept;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.port_value = out_port_r;
  assign out_ch.last       = out_last_r;

endmodule

`default_nettype wire
